// File: src/bitmap_block_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Property wrappers shared by the allocator RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while rst_n is low
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BBA_ASSERT_IMP(label, ante, cons, msg)
`define BBA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: src/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Sizes, memory geometry, command and state codes shared by the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NUM_BLOCKS = 65536;
    localparam int WORD_BITS  = 64;      // 8 .. 64

    localparam int LIMIT  = (NUM_BLOCKS < 65536) ? NUM_BLOCKS : 65536;
    localparam int NWORDS = (LIMIT + WORD_BITS - 1) / WORD_BITS;

    // summary memory: one "word full" bit per bitmap word, MSB first
    localparam int SUM_BITS  = 64;
    localparam int SUM_SH    = 6;
    localparam int SUM_WORDS = (NWORDS + SUM_BITS - 1) / SUM_BITS;

    localparam int BM_AW  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SUM_AW = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int BIDX_W = $clog2(WORD_BITS);

    // first-zero finder geometry
    localparam int FFZ_BITS   = 64;
    localparam int GROUP_BITS = 8;
    localparam int FFZ_GROUPS = FFZ_BITS / GROUP_BITS;
    localparam int GRP_IDX_W  = 3;
    localparam int FFZ_IDX_W  = 6;

    // block / WORD_BITS as a multiply by a reciprocal; exact for 16-bit blocks
    localparam int RECIP_SH = 24;
    localparam int RECIP    = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int PROD_W   = 16 + RECIP_W;

    typedef logic [15:0]           blk_t;
    typedef logic [16:0]           count_t;
    typedef logic [WORD_BITS-1:0]  bm_word_t;
    typedef logic [SUM_BITS-1:0]   sum_word_t;

    localparam count_t COUNT_MAX = 17'd65536;

    // bits past the last real block read as occupied
    localparam int LAST_BITS = LIMIT - (NWORDS - 1) * WORD_BITS;
    localparam bm_word_t BM_PAD_LAST =
        bm_word_t'((65'd1 << (WORD_BITS - LAST_BITS)) - 65'd1);
    localparam int SUM_LAST = NWORDS - (SUM_WORDS - 1) * SUM_BITS;
    localparam sum_word_t SUM_PAD_LAST =
        sum_word_t'((65'd1 << (SUM_BITS - SUM_LAST)) - 65'd1);

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_FREE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEC,
        ST_RD,
        ST_MOD,
        ST_SREAD,
        ST_SFFZ,
        ST_SWAIT,
        ST_SCHK,
        ST_WREAD,
        ST_WFFZ,
        ST_WWAIT,
        ST_WCHK
    } state_t;

    typedef struct packed {
        logic                 found;
        logic [FFZ_IDX_W-1:0] idx;
    } ffz_res_t;

endpackage

// File: src/bba_ffz.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator first-zero finder
// Two-stage search for the most significant clear bit of a 64-bit word.
// ----------------------------------------------------------------------------
module bba_ffz
    import bba_pkg::*;
(
    input  logic                clk,
    input  logic [FFZ_BITS-1:0] vec,
    output ffz_res_t            res
);

    logic [FFZ_GROUPS-1:0]                 gz_next;
    logic [FFZ_GROUPS-1:0]                 gz_reg;
    logic [FFZ_GROUPS-1:0][GRP_IDX_W-1:0]  gi_next;
    logic [FFZ_GROUPS-1:0][GRP_IDX_W-1:0]  gi_reg;
    ffz_res_t                              res_next;
    ffz_res_t                              res_reg;

    // stage 1: per-group zero flag and index, group 0 is the top byte
    always_comb
    begin
        logic [GROUP_BITS-1:0] grp;
        grp     = '0;
        gz_next = '0;
        gi_next = '0;
        for (int g = 0; g < FFZ_GROUPS; g++)
        begin
            grp        = vec[FFZ_BITS - 1 - g * GROUP_BITS -: GROUP_BITS];
            gz_next[g] = ~&grp;
            for (int k = 0; k < GROUP_BITS; k++)
            begin
                if (!grp[k])
                begin
                    gi_next[g] = GRP_IDX_W'(GROUP_BITS - 1 - k);
                end
            end
        end
    end

    // stage 2: first group holding a zero
    always_comb
    begin
        res_next       = '0;
        res_next.found = |gz_reg;
        for (int g = FFZ_GROUPS - 1; g >= 0; g--)
        begin
            if (gz_reg[g])
            begin
                res_next.idx = {GRP_IDX_W'(g), gi_reg[g]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gz_reg  <= gz_next;
        gi_reg  <= gi_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: src/bitmap_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator core
// First-fit block allocator over a one-bit-per-block occupancy bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low. command selects read bit, write bit, allocate or free.
//   Result channel: done is high for one cycle with result_block, read_bit,
//   status and free_blocks; the receiver cannot stall it.
//   Config channel: cfg_valid/cfg_ready load initial_free_count (saturated
//   to 65536) into the free counter; cfg_ready is always high. Load it only
//   while no command is in flight.
//   Sequencing: read, write and free pass through decode, RAM read and
//   modify states before done. Allocate reads and searches one summary word
//   per pass, s being the number of summary words scanned (1 .. SUM_WORDS,
//   16 by default), then reads and searches the chosen bitmap word; with a
//   zero counter it answers in the next cycle. Each pass goes through the
//   registered RAM read and the two-stage first-zero finder.
//   A new command may be accepted in the cycle done is high.
//   Reset: busy stays high while a clearing pass zeroes all NWORDS (1024 by
//   default) bitmap words and the summary memory; the counter is 0.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_core_macros.svh"

module bitmap_block_allocator_core
    import bba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  blk_t        block_number,
    input  logic        bit_value,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  count_t      initial_free_count,

    output logic        done,
    output blk_t        result_block,
    output logic        read_bit,
    output logic        status,
    output count_t      free_blocks
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg,      state_next;
    logic [BM_AW-1:0]     clr_reg,        clr_next;
    count_t               free_count_reg, free_count_next;
    logic                 done_reg,       done_next;

    cmd_t                 cmd_reg,        cmd_next;
    blk_t                 blk_reg,        blk_next;
    logic                 bv_reg,         bv_next;
    blk_t                 q_reg,          q_next;        // word index of blk
    logic                 inrange_reg,    inrange_next;
    logic [BIDX_W-1:0]    bitidx_reg,     bitidx_next;   // bit within word
    logic [SUM_AW-1:0]    sidx_reg,       sidx_next;     // summary scan pointer
    logic [BM_AW-1:0]     widx_reg,       widx_next;     // chosen bitmap word
    logic [FFZ_IDX_W-1:0] sbit_reg,       sbit_next;     // its summary bit
    sum_word_t            sum_word_reg,   sum_word_next;
    bm_word_t             word_reg,       word_next;
    blk_t                 res_blk_reg,    res_blk_next;
    logic                 rbit_reg,       rbit_next;
    logic                 status_reg,     status_next;

    // ------------------------------------------------------------------
    // Memories: bitmap words and per-word "full" summary
    // ------------------------------------------------------------------
    bm_word_t             bm_mem [NWORDS];
    logic                 bm_we;
    logic [BM_AW-1:0]     bm_waddr;
    bm_word_t             bm_wdata;
    logic [BM_AW-1:0]     bm_raddr;
    bm_word_t             bm_rdata_reg;

    sum_word_t            sum_mem [SUM_WORDS];
    logic                 sum_we;
    logic [SUM_AW-1:0]    sum_waddr;
    sum_word_t            sum_wdata;
    logic [SUM_AW-1:0]    sum_raddr;
    sum_word_t            sum_rdata_reg;

    logic [FFZ_BITS-1:0]  ffz_in;
    ffz_res_t             ffz_res;

    logic                 accept;
    logic [BM_AW-1:0]     q_addr;
    logic [SUM_AW-1:0]    q_sidx;
    logic [SUM_SH-1:0]    q_sbit;

    assign accept = start && !busy;
    assign q_addr = q_reg[BM_AW-1:0];
    assign q_sidx = SUM_AW'(q_reg >> SUM_SH);
    assign q_sbit = q_reg[SUM_SH-1:0];

    // padding past the last block reads as occupied
    function automatic bm_word_t bm_pad(input logic [BM_AW-1:0] a);
        return (a == BM_AW'(NWORDS - 1)) ? BM_PAD_LAST : '0;
    endfunction

    function automatic sum_word_t sum_pad(input logic [SUM_AW-1:0] a);
        return (a == SUM_AW'(SUM_WORDS - 1)) ? SUM_PAD_LAST : '0;
    endfunction

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        bm_rdata_reg <= bm_mem[bm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_rdata_reg <= sum_mem[sum_raddr];
    end

    bba_ffz u_ffz (
        .clk (clk),
        .vec (ffz_in),
        .res (ffz_res)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == BM_AW'(NWORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_t'(command) == CMD_ALLOC)
                    begin
                        // zero counter answers at once
                        state_next = (free_count_reg == '0) ? ST_IDLE : ST_SREAD;
                    end
                    else
                    begin
                        state_next = ST_DEC;
                    end
                end
            end
            ST_DEC:   state_next = ST_RD;
            ST_RD:    state_next = ST_MOD;
            ST_MOD:   state_next = ST_IDLE;
            ST_SREAD: state_next = ST_SFFZ;
            ST_SFFZ:  state_next = ST_SWAIT;
            ST_SWAIT: state_next = ST_SCHK;
            ST_SCHK:
            begin
                if (ffz_res.found)
                begin
                    state_next = ST_WREAD;
                end
                else if (sidx_reg == SUM_AW'(SUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SREAD;
                end
            end
            ST_WREAD: state_next = ST_WFFZ;
            ST_WFFZ:  state_next = ST_WWAIT;
            ST_WWAIT: state_next = ST_WCHK;
            ST_WCHK:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        bm_word_t          mod_word;
        sum_word_t         sum_mod;
        logic              full_word;
        blk_t              qw;
        blk_t              rem;
        logic [31:0]       res_wide;
        logic [PROD_W-1:0] prod;
        logic [BIDX_W-1:0] set_idx;

        mod_word  = '0;
        sum_mod   = '0;
        full_word = 1'b0;
        qw        = '0;
        rem       = '0;
        res_wide  = '0;
        prod      = '0;
        set_idx   = '0;

        bm_we     = 1'b0;
        bm_waddr  = q_addr;
        bm_wdata  = '0;
        bm_raddr  = widx_reg;
        sum_we    = 1'b0;
        sum_waddr = sidx_reg;
        sum_wdata = '0;
        sum_raddr = sidx_reg;
        // bitmap word, left-aligned and padded with ones below
        ffz_in    = FFZ_BITS'({bm_rdata_reg | bm_pad(widx_reg), {FFZ_BITS{1'b1}}}
                              >> WORD_BITS);

        clr_next        = clr_reg;
        free_count_next = free_count_reg;
        done_next       = 1'b0;
        cmd_next        = cmd_reg;
        blk_next        = blk_reg;
        bv_next         = bv_reg;
        q_next          = q_reg;
        inrange_next    = inrange_reg;
        bitidx_next     = bitidx_reg;
        sidx_next       = sidx_reg;
        widx_next       = widx_reg;
        sbit_next       = sbit_reg;
        sum_word_next   = sum_word_reg;
        word_next       = word_reg;
        res_blk_next    = res_blk_reg;
        rbit_next       = rbit_reg;
        status_next     = status_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                bm_we     = 1'b1;
                bm_waddr  = clr_reg;
                sum_we    = ({1'b0, clr_reg} < (BM_AW + 1)'(SUM_WORDS));
                sum_waddr = SUM_AW'(clr_reg);
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = cmd_t'(command);
                    blk_next  = block_number;
                    bv_next   = bit_value;
                    sidx_next = '0;
                    if (cmd_t'(command) == CMD_ALLOC && free_count_reg == '0)
                    begin
                        done_next    = 1'b1;
                        status_next  = 1'b1;
                        res_blk_next = '0;
                        rbit_next    = 1'b0;
                    end
                end
            end
            ST_DEC:
            begin
                prod         = PROD_W'(blk_reg) * PROD_W'(RECIP);
                q_next       = 16'(prod >> RECIP_SH);
                inrange_next = ({1'b0, blk_reg} < 17'(LIMIT));
            end
            ST_RD:
            begin
                bm_raddr    = q_addr;
                sum_raddr   = q_sidx;
                qw          = 16'(q_reg * 16'(WORD_BITS));
                rem         = blk_reg - qw;
                bitidx_next = BIDX_W'(WORD_BITS - 1) - rem[BIDX_W-1:0];
            end
            ST_MOD:
            begin
                mod_word             = bm_rdata_reg;
                mod_word[bitidx_reg] = (cmd_reg == CMD_WRITE) ? bv_reg : 1'b0;
                full_word            = &(mod_word | bm_pad(q_addr));
                sum_mod              = sum_rdata_reg;
                sum_mod[SUM_SH'(SUM_BITS - 1) - q_sbit] = full_word;

                done_next    = 1'b1;
                status_next  = 1'b0;
                res_blk_next = blk_reg;
                rbit_next    = (cmd_reg == CMD_READ) && inrange_reg
                               && bm_rdata_reg[bitidx_reg];

                if (cmd_reg != CMD_READ && inrange_reg)
                begin
                    bm_we     = 1'b1;
                    bm_waddr  = q_addr;
                    bm_wdata  = mod_word;
                    sum_we    = 1'b1;
                    sum_waddr = q_sidx;
                    sum_wdata = sum_mod;
                    if (cmd_reg == CMD_FREE && free_count_reg < COUNT_MAX)
                    begin
                        free_count_next = free_count_reg + 1'b1;
                    end
                end
            end
            ST_SREAD:
            begin
                sum_raddr = sidx_reg;
            end
            ST_SFFZ:
            begin
                ffz_in        = sum_rdata_reg | sum_pad(sidx_reg);
                sum_word_next = sum_rdata_reg;
            end
            ST_SCHK:
            begin
                if (ffz_res.found)
                begin
                    widx_next = BM_AW'({sidx_reg, ffz_res.idx});
                    sbit_next = ffz_res.idx;
                end
                else if (sidx_reg == SUM_AW'(SUM_WORDS - 1))
                begin
                    // every word full
                    done_next    = 1'b1;
                    status_next  = 1'b1;
                    res_blk_next = '0;
                    rbit_next    = 1'b0;
                end
                else
                begin
                    sidx_next = sidx_reg + 1'b1;
                end
            end
            ST_WREAD:
            begin
                bm_raddr = widx_reg;
            end
            ST_WFFZ:
            begin
                word_next = bm_rdata_reg;
            end
            ST_WCHK:
            begin
                done_next = 1'b1;
                rbit_next = 1'b0;
                if (ffz_res.found && 7'(ffz_res.idx) < 7'(WORD_BITS))
                begin
                    set_idx           = BIDX_W'(WORD_BITS - 1) - BIDX_W'(ffz_res.idx);
                    mod_word          = word_reg;
                    mod_word[set_idx] = 1'b1;
                    full_word         = &(mod_word | bm_pad(widx_reg));
                    sum_mod           = sum_word_reg;
                    sum_mod[SUM_SH'(SUM_BITS - 1) - sbit_reg] = full_word;

                    bm_we     = 1'b1;
                    bm_waddr  = widx_reg;
                    bm_wdata  = mod_word;
                    sum_we    = 1'b1;
                    sum_waddr = sidx_reg;
                    sum_wdata = sum_mod;

                    res_wide        = 32'(widx_reg) * 32'(WORD_BITS) + 32'(ffz_res.idx);
                    res_blk_next    = res_wide[15:0];
                    status_next     = 1'b0;
                    free_count_next = free_count_reg - 1'b1;
                end
                else
                begin
                    res_blk_next = '0;
                    status_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // counter load; the user must load it only while no command is in flight, the block does not enforce it
        if (cfg_valid)
        begin
            free_count_next = (initial_free_count > COUNT_MAX) ? COUNT_MAX
                                                                : initial_free_count;
        end
    end

    // ------------------------------------------------------------------
    // Register update
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            free_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            free_count_reg <= free_count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        blk_reg      <= blk_next;
        bv_reg       <= bv_next;
        q_reg        <= q_next;
        inrange_reg  <= inrange_next;
        bitidx_reg   <= bitidx_next;
        sidx_reg     <= sidx_next;
        widx_reg     <= widx_next;
        sbit_reg     <= sbit_next;
        sum_word_reg <= sum_word_next;
        word_reg     <= word_next;
        res_blk_reg  <= res_blk_next;
        rbit_reg     <= rbit_next;
        status_reg   <= status_next;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign result_block = res_blk_reg;
    assign read_bit     = rbit_reg;
    assign status       = status_reg;
    assign free_blocks  = free_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BBA_ASSERT_NEXT(a_accept_progress, accept, busy || done_reg, "accepted command lost")
    `BBA_ASSERT_IMP(a_done_idle, done_reg, state_reg == ST_IDLE, "result strobe while busy")
    `BBA_ASSERT_IMP(a_count_bound, 1'b1, free_count_reg <= COUNT_MAX, "free count overflow")
    `BBA_ASSERT_IMP(a_nofree_alloc, done_reg && status_reg, cmd_reg == CMD_ALLOC && res_blk_reg == '0, "bad no-free result")
    `BBA_ASSERT_IMP(a_alloc_dec, done_reg && cmd_reg == CMD_ALLOC && !status_reg, free_count_reg == $past(free_count_reg) - 17'd1, "allocate did not decrement")

endmodule
